>>> hdl/ulf_pkg.sv
// package for the serial receive line buffer
// ring depth, pointer helpers, result kinds and controller states; no dependencies
`default_nettype none

package ulf_pkg;

  localparam int RING_DEPTH = 128;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LEN_W      = 6;
  localparam int MLEN_W     = 7;
  localparam int MAXLEN_CAP = 64;

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef enum logic [2:0] {
    KIND_STORED  = 3'd0,
    KIND_IGNORED = 3'd1,
    KIND_DROPPED = 3'd2,
    KIND_NO_LINE = 3'd3,
    KIND_LINE    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_POP   = 3'b100
  } state_t;

  function automatic ptr_t ptr_adv(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(RING_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  // reader buffer size clamped to 1..64, minus the terminator
  function automatic len_t char_limit(input logic [MLEN_W-1:0] m);
    logic [MLEN_W-1:0] c;
    if (m == '0) c = MLEN_W'(1);
    else if (m > MLEN_W'(MAXLEN_CAP)) c = MLEN_W'(MAXLEN_CAP);
    else c = m;
    return LEN_W'(c - MLEN_W'(1));
  endfunction

endpackage

`default_nettype wire

>>> hdl/ulf_req_if.sv
// request channel of the serial receive line buffer
// valid/ready handshake with byte event and line read fields; no dependencies
`default_nettype none

interface ulf_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       rx_ready;
  logic [7:0] rx_byte;
  logic [6:0] max_len;

  modport source (output valid, req_type, rx_ready, rx_byte, max_len, input ready);
  modport sink   (input valid, req_type, rx_ready, rx_byte, max_len, output ready);
endinterface

`default_nettype wire

>>> hdl/ulf_resp_if.sv
// result channel of the serial receive line buffer
// valid/ready handshake with result fields; no dependencies
`default_nettype none

interface ulf_resp_if;
  logic       valid;
  logic       ready;
  logic [2:0] resp_kind;
  logic [7:0] line_char;
  logic       char_valid;
  logic       last;
  logic [5:0] line_length;
  logic       overrun_seen;

  modport source (output valid, resp_kind, line_char, char_valid, last, line_length,
                  overrun_seen, input ready);
  modport sink   (input valid, resp_kind, line_char, char_valid, last, line_length,
                  overrun_seen, output ready);
endinterface

`default_nettype wire

>>> hdl/uart_rx_line_fifo_unit.sv
// serial receive ring buffer with newline-delimited line reads
// depends on ulf_pkg, ulf_req_if, ulf_resp_if
//
//   channel  dir  handshake     carries
//   req      in   valid/ready   req_type, rx_ready, rx_byte, max_len
//   resp     out  valid/ready   resp_kind, line_char, char_valid, last,
//                               line_length, overrun_seen
//
// byte events and line reads that pop nothing are answered from idle; a line
// read popping n characters passes a fetch state, one memory read of the first
// character, then one character a cycle from the ring's read port unless stalled
// rst is synchronous; pointers and flags clear, ring contents are left as is
// a stalled resp holds the result register and the pop, no new item is taken
`default_nettype none

module uart_rx_line_fifo_unit (
  input  wire logic clk,
  input  wire logic rst,
  ulf_req_if.sink   req,
  ulf_resp_if.source resp
);
  import ulf_pkg::*;

  logic [7:0] ring [RING_DEPTH];
  logic [7:0] rd_data;
  ptr_t       rd_addr;
  logic       wr_en;

  state_t state, state_next;
  ptr_t   write_ptr, write_ptr_next;
  ptr_t   read_ptr, read_ptr_next;
  logic   overrun, overrun_next;
  logic   line_pending, line_pending_next;
  len_t   limit, limit_next;
  len_t   cnt, cnt_next;

  logic       out_valid, out_valid_next;
  kind_t      out_kind, out_kind_next;
  logic [7:0] out_char, out_char_next;
  logic       out_cvalid, out_cvalid_next;
  logic       out_last, out_last_next;
  len_t       out_len, out_len_next;
  logic       out_ovr, out_ovr_next;

  logic slot_free, accept, pop, pop_last;
  len_t req_limit;
  ptr_t wr_adv;

  assign slot_free = !out_valid || resp.ready;
  assign req.ready = (state == ST_IDLE) && slot_free;
  assign accept    = req.valid && req.ready;
  assign pop       = (state == ST_POP) && slot_free;
  assign req_limit = char_limit(req.max_len);
  assign wr_adv    = ptr_adv(write_ptr);
  assign pop_last  = (rd_data == NEWLINE) || (ptr_adv(read_ptr) == write_ptr)
                     || (cnt + LEN_W'(1) == limit);
  assign rd_addr   = pop ? ptr_adv(read_ptr) : read_ptr;
  assign wr_en     = accept && !req.req_type && req.rx_ready && (wr_adv != read_ptr);

  always_comb begin
    state_next        = state;
    write_ptr_next    = write_ptr;
    read_ptr_next     = read_ptr;
    overrun_next      = overrun;
    line_pending_next = line_pending;
    limit_next        = limit;
    cnt_next          = cnt;
    out_valid_next    = out_valid && !resp.ready;
    out_kind_next     = out_kind;
    out_char_next     = out_char;
    out_cvalid_next   = out_cvalid;
    out_last_next     = out_last;
    out_len_next      = out_len;
    out_ovr_next      = out_ovr;

    if (accept) begin
      out_valid_next  = 1'b1;
      out_char_next   = '0;
      out_cvalid_next = 1'b0;
      out_last_next   = 1'b1;
      out_len_next    = '0;
      if (!req.req_type) begin
        if (!req.rx_ready) begin
          out_kind_next = KIND_IGNORED;
        end else if (wr_adv == read_ptr) begin
          overrun_next  = 1'b1;
          out_kind_next = KIND_DROPPED;
        end else begin
          write_ptr_next = wr_adv;
          if (req.rx_byte == NEWLINE) line_pending_next = 1'b1;
          out_kind_next = KIND_STORED;
        end
      end else if (!line_pending) begin
        out_kind_next = KIND_NO_LINE;
      end else if ((read_ptr == write_ptr) || (req_limit == '0)) begin
        out_kind_next     = KIND_LINE;
        line_pending_next = 1'b0;
      end else begin
        out_valid_next = 1'b0;
        limit_next     = req_limit;
        cnt_next       = '0;
        state_next     = ST_FETCH;
      end
      out_ovr_next = overrun_next;
    end

    unique case (state)
      ST_IDLE: begin
      end
      ST_FETCH: begin
        state_next = ST_POP;
      end
      ST_POP: begin
        if (pop) begin
          out_valid_next  = 1'b1;
          out_kind_next   = KIND_LINE;
          out_char_next   = rd_data;
          out_cvalid_next = 1'b1;
          out_last_next   = pop_last;
          out_len_next    = pop_last ? cnt + LEN_W'(1) : '0;
          out_ovr_next    = overrun;
          read_ptr_next   = ptr_adv(read_ptr);
          cnt_next        = cnt + LEN_W'(1);
          if (pop_last) begin
            line_pending_next = 1'b0;
            state_next        = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) ring[write_ptr] <= req.rx_byte;
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      write_ptr    <= '0;
      read_ptr     <= '0;
      overrun      <= 1'b0;
      line_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      write_ptr    <= write_ptr_next;
      read_ptr     <= read_ptr_next;
      overrun      <= overrun_next;
      line_pending <= line_pending_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    limit      <= limit_next;
    cnt        <= cnt_next;
    out_kind   <= out_kind_next;
    out_char   <= out_char_next;
    out_cvalid <= out_cvalid_next;
    out_last   <= out_last_next;
    out_len    <= out_len_next;
    out_ovr    <= out_ovr_next;
  end

  assign resp.valid        = out_valid;
  assign resp.resp_kind    = out_kind;
  assign resp.line_char    = out_char;
  assign resp.char_valid   = out_cvalid;
  assign resp.last         = out_last;
  assign resp.line_length  = out_len;
  assign resp.overrun_seen = out_ovr;

  // overrun is sticky until reset
  a_overrun_sticky: assert property (@(posedge clk) disable iff (rst)
    overrun |=> overrun)
    else $error("overrun flag cleared");

  // each popped character advances the read pointer by one entry
  a_pop_advance: assert property (@(posedge clk) disable iff (rst)
    pop |=> read_ptr == ptr_adv($past(read_ptr)))
    else $error("read pointer did not advance on pop");

  // the pop count never reaches the limit while popping
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> (cnt < limit))
    else $error("pop count beyond limit");

  // a popped line never runs past the write pointer
  a_not_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> (read_ptr != write_ptr))
    else $error("pop from empty ring");

  // the final line result leaves no line pending
  a_line_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last && (out_kind == KIND_LINE) && (state == ST_IDLE))
      |-> !line_pending || !$stable(write_ptr) || $past(accept))
    else $error("line still pending after line read");

endmodule

`default_nettype wire

>>> tb/uart_rx_line_fifo_unit_tb.sv
`timescale 1ns / 100ps
// testbench for the serial receive line buffer: directed and random byte events and line reads
// a predictor tracks ring, pointers and flags and checks every result item in order
// depends on ulf_pkg, ulf_req_if, ulf_resp_if and uart_rx_line_fifo_unit

module uart_rx_line_fifo_unit_tb;
  import ulf_pkg::*;

  localparam int LIMIT        = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic       req_type;
    logic       rx_ready;
    logic [7:0] rx_byte;
    logic [6:0] max_len;
  } req_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       cv;
    logic       last;
    logic [5:0] len;
    logic       ovr;
  } line_result_t;

  logic clk;
  logic rst;

  ulf_req_if  req_ch ();
  ulf_resp_if resp_ch ();

  uart_rx_line_fifo_unit dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .resp (resp_ch)
  );

  // predictor state
  logic [7:0] model_ring [RING_DEPTH];
  ptr_t       wr_idx;
  ptr_t       rd_idx;
  logic       sticky_ovr;
  logic       line_ready;

  line_result_t line_results[$];

  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_request;
  int hold_left;
  int mismatches;
  int items_sent;
  int results_seen;
  int lines_popped;
  int bytes_dropped;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic ptr_t ring_next(input ptr_t p);
    return (int'(p) == RING_DEPTH - 1) ? ptr_t'(0) : ptr_t'(p + 1'b1);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == NEWLINE) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic push_line_result(input kind_t kind, input logic [7:0] ch, input logic cv,
                                  input logic last, input logic [5:0] len);
    line_result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.cv   = cv;
    r.last = last;
    r.len  = len;
    r.ovr  = sticky_ovr;
    line_results.push_back(r);
  endtask

  task automatic predict_line_step(input req_item_t it);
    ptr_t         nxt;
    logic [6:0]   m;
    int           lim;
    int           n;
    logic [7:0]   c;
    line_result_t r;
    if (!it.req_type) begin
      if (!it.rx_ready) begin
        push_line_result(KIND_IGNORED, 8'h00, 1'b0, 1'b1, 6'd0);
      end else begin
        nxt = ring_next(wr_idx);
        if (nxt == rd_idx) begin
          sticky_ovr = 1'b1;
          bytes_dropped++;
          push_line_result(KIND_DROPPED, 8'h00, 1'b0, 1'b1, 6'd0);
        end else begin
          model_ring[wr_idx] = it.rx_byte;
          wr_idx = nxt;
          if (it.rx_byte == NEWLINE) line_ready = 1'b1;
          push_line_result(KIND_STORED, 8'h00, 1'b0, 1'b1, 6'd0);
        end
      end
    end else if (!line_ready) begin
      push_line_result(KIND_NO_LINE, 8'h00, 1'b0, 1'b1, 6'd0);
    end else begin
      m = it.max_len;
      if (m == 7'd0) m = 7'd1;
      if (int'(m) > MAXLEN_CAP) m = 7'(MAXLEN_CAP);
      lim = int'(m) - 1;
      n = 0;
      while (rd_idx != wr_idx && n < lim) begin
        c = model_ring[rd_idx];
        rd_idx = ring_next(rd_idx);
        n++;
        push_line_result(KIND_LINE, c, 1'b1, 1'b0, 6'd0);
        if (c == NEWLINE) break;
      end
      line_ready = 1'b0;
      if (n == 0) begin
        push_line_result(KIND_LINE, 8'h00, 1'b0, 1'b1, 6'd0);
      end else begin
        r = line_results.pop_back();
        r.last = 1'b1;
        r.len  = 6'(n);
        line_results.push_back(r);
        lines_popped++;
      end
    end
  endtask

  task automatic send_item(input req_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= it.req_type;
    req_ch.rx_ready <= it.rx_ready;
    req_ch.rx_byte  <= it.rx_byte;
    req_ch.max_len  <= it.max_len;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_line_step(it);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    req_item_t it;
    it.req_type = 1'b0;
    it.rx_ready = 1'b1;
    it.rx_byte  = b;
    it.max_len  = 7'($urandom);
    send_item(it);
  endtask

  task automatic send_spurious(input logic [7:0] b);
    req_item_t it;
    it.req_type = 1'b0;
    it.rx_ready = 1'b0;
    it.rx_byte  = b;
    it.max_len  = 7'($urandom);
    send_item(it);
  endtask

  task automatic send_read(input logic [6:0] m);
    req_item_t it;
    it.req_type = 1'b1;
    it.rx_ready = 1'($urandom);
    it.rx_byte  = 8'($urandom);
    it.max_len  = m;
    send_item(it);
  endtask

  // extremes, empty reads, cleared line flag, truncation and saturation
  task automatic test_directed();
    tx_idle_pct = 9;
    rx_idle_pct = 52;
    send_read(7'd64);
    send_spurious(8'hFF);
    send_spurious(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(NEWLINE);
    send_read(7'd0);
    send_read(7'd127);
    send_byte(8'h41);
    send_byte(NEWLINE);
    send_read(7'd127);
    send_byte(8'h42);
    send_read(7'd5);
    send_byte(NEWLINE);
    send_read(7'd2);
    send_byte(NEWLINE);
    send_read(7'd1);
    send_read(7'd64);
    send_byte(NEWLINE);
    send_read(7'd64);
    send_read(7'd65);
  endtask

  // mostly whole lines followed by a read, with noise in between
  task automatic test_random_lines(input int tx_pct, input int rx_pct, input int count);
    int stop;
    int len;
    int pick;
    int m;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(70, 40) : $urandom_range(12, 0);
        if (len > stop - items_sent - 2) len = stop - items_sent - 2;
        if (len < 0) len = 0;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) send_spurious(8'($urandom));
          send_byte(plain_byte());
        end
        send_byte(NEWLINE);
        pick = $urandom_range(99);
        if (pick < 55) m = len + 1 + $urandom_range(4, 0);
        else if (pick < 70) m = $urandom_range(len + 1, 0);
        else if (pick < 85) m = $urandom_range(127, 65);
        else m = $urandom_range(127, 0);
        if (m > 127) m = 127;
        send_read(7'(m));
      end else if (pick < 80) begin
        send_spurious(8'($urandom));
      end else if (pick < 90) begin
        send_read(7'($urandom));
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  // fill the ring, drop a newline and more bytes, then read some back
  task automatic test_overrun();
    int free_slots;
    tx_idle_pct = 52;
    rx_idle_pct = 9;
    send_byte(NEWLINE);
    free_slots = RING_DEPTH - 1 - ((int'(wr_idx) - int'(rd_idx) + RING_DEPTH) % RING_DEPTH);
    repeat (free_slots) send_byte(plain_byte());
    send_byte(NEWLINE);
    send_byte(plain_byte());
    send_byte(8'hFF);
    send_read(7'd64);
    repeat (2) begin
      send_byte(NEWLINE);
      send_read(7'($urandom_range(127, 64)));
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 1'b1;
    repeat (4) send_byte(plain_byte());
    send_byte(NEWLINE);
    send_read(7'd64);
    send_spurious(8'($urandom));
    send_read(7'd20);
  endtask

  always @(posedge clk) begin : drive_ready
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      resp_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      resp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    line_result_t want;
    if (!rst && resp_ch.valid && resp_ch.ready) begin
      results_seen++;
      if (line_results.size() == 0) begin
        note_mismatch($sformatf("result kind %0d with nothing outstanding", resp_ch.resp_kind));
      end else begin
        want = line_results.pop_front();
        if (resp_ch.resp_kind !== want.kind)
          note_mismatch($sformatf("resp_kind %0d, want %0d", resp_ch.resp_kind, want.kind));
        if (resp_ch.line_char !== want.ch)
          note_mismatch($sformatf("line_char %h, want %h", resp_ch.line_char, want.ch));
        if (resp_ch.char_valid !== want.cv)
          note_mismatch($sformatf("char_valid %b, want %b", resp_ch.char_valid, want.cv));
        if (resp_ch.last !== want.last)
          note_mismatch($sformatf("last %b, want %b", resp_ch.last, want.last));
        if (resp_ch.line_length !== want.len)
          note_mismatch($sformatf("line_length %0d, want %0d", resp_ch.line_length, want.len));
        if (resp_ch.overrun_seen !== want.ovr)
          note_mismatch($sformatf("overrun_seen %b, want %b", resp_ch.overrun_seen, want.ovr));
      end
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < LIMIT; cycle_count++) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", LIMIT, line_results.size());
    $display("simulation failed");
    $finish;
  end

  initial begin : run_tests
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = 1'b0;
    req_ch.rx_ready = 1'b0;
    req_ch.rx_byte  = 8'h00;
    req_ch.max_len  = 7'd0;
    resp_ch.ready   = 1'b0;
    hold_request    = 1'b0;
    hold_left       = 0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    mismatches      = 0;
    items_sent      = 0;
    results_seen    = 0;
    lines_popped    = 0;
    bytes_dropped   = 0;
    wr_idx          = '0;
    rd_idx          = '0;
    sticky_ovr      = 1'b0;
    line_ready      = 1'b0;
    for (int i = 0; i < RING_DEPTH; i++) model_ring[i] = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_lines(9, 52, 8);
    test_random_lines(52, 9, 8);
    test_random_lines(0, 0, 8);
    test_overrun();
    test_backpressure();

    req_ch.valid <= 1'b0;
    while (line_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items and %0d results: %0d reads returned data, %0d bytes dropped",
             items_sent, results_seen, lines_popped, bytes_dropped);
    $display("phases: directed, random lines under three idle mixes, ring overrun, long stall");
    if (mismatches == 0 && line_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, line_results.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
